[rtl/tts_pkg.sv]
// shared types and constants for the text terminal scroll writer
// no dependencies; imported by tts_ctrl, tts_dp and text_terminal_scroll_writer
package tts_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  typedef enum logic {
    ACT_PUT  = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // capture a new input beat
    logic exec;     // do the memory access / update for the held beat
    logic respond;  // result beat on the output ports this cycle
  } dp_cmd_t;

endpackage

[rtl/text_terminal_scroll_writer.sv]
// top level of the text terminal scroll writer
// depends on tts_pkg, tts_ctrl and tts_dp
//
// command channel: a beat with action, char_code, read_row and read_column
//   is taken at an edge where start is high and busy is low; a put writes
//   char_code at the cursor of the bottom row (the newline code scrolls
//   instead), a read returns one cell as attribute byte over character byte
// result channel: result_valid is high for exactly one cycle with
//   cursor_column, cursor_row, cell_value and scrolled; the receiver
//   cannot stall, so each result beat must be taken when shown
// config channel: cfg_valid/cfg_ready with cfg_data sets the text
//   attribute; cfg_ready is always high, write it only while idle
// timing: busy is high only in the access cycle after the beat is taken;
//   the result is shown in the cycle after that, and a new beat can go in
//   while it is shown; no beat is taken during the screen read
// scroll: rotates the physical row origin; each row keeps a fill length
//   and fill attribute, so no cells are moved or cleared
// reset: rst is synchronous; the screen reads as grey-on-black spaces at
//   once, cursor at column 0, attribute 07, no clearing pass is needed
module text_terminal_scroll_writer #(
  parameter int COLUMNS = tts_pkg::COLUMNS_DEF,
  parameter int ROWS    = tts_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // command beat
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [7:0]  char_code,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_column,
  // result beat
  output logic        result_valid,
  output logic [6:0]  cursor_column,
  output logic [4:0]  cursor_row,
  output logic [15:0] cell_value,
  output logic        scrolled,
  // attribute register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import tts_pkg::*;

  dp_cmd_t cmd;

  // attribute register can always take a beat
  assign cfg_ready    = 1'b1;
  assign result_valid = cmd.respond;

  tts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  tts_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_write     (cfg_valid & cfg_ready),
    .cfg_data      (cfg_data),
    .action        (action),
    .char_code     (char_code),
    .read_row      (read_row),
    .read_column   (read_column),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row),
    .cell_value    (cell_value),
    .scrolled      (scrolled)
  );

endmodule

[rtl/tts_ctrl.sv]
// controller state machine for the text terminal scroll writer
// depends on tts_pkg; drives tts_dp through a dp_cmd_t bundle
module tts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output tts_pkg::dp_cmd_t  cmd
);
  import tts_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    busy        = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        // next beat may be taken while this result is shown
        cmd.respond = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/tts_dp.sv]
// datapath: screen memory, per-row fill metadata, cursor and row origin
// depends on tts_pkg; sequenced by tts_ctrl
module tts_dp #(
  parameter int COLUMNS = tts_pkg::COLUMNS_DEF,
  parameter int ROWS    = tts_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tts_pkg::dp_cmd_t  cmd,
  input  logic              cfg_write,
  input  logic [7:0]        cfg_data,
  input  logic              action,
  input  logic [7:0]        char_code,
  input  logic [4:0]        read_row,
  input  logic [6:0]        read_column,
  output logic [6:0]        cursor_column,
  output logic [4:0]        cursor_row,
  output logic [15:0]       cell_value,
  output logic              scrolled
);
  import tts_pkg::*;

  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FILL_W = $clog2(COLUMNS + 1);
  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  // held input beat
  logic             in_action;
  logic [7:0]       in_char;
  logic [4:0]       in_row;
  logic [6:0]       in_col;

  // control state
  logic [7:0]       attr;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] bottom;       // physical row currently shown as bottom
  logic [7:0]       bottom_attr;  // fill attribute of the bottom row
  logic [ROWS-1:0]  meta_valid;

  // storage
  logic [15:0]       screen [CELLS];
  logic [FILL_W-1:0] meta_fill [ROWS];
  logic [7:0]        meta_attr [ROWS];

  // registered read side
  logic [15:0]       mem_q;
  logic [FILL_W-1:0] meta_fill_q;
  logic [7:0]        meta_attr_q;
  logic              meta_valid_q;

  // result registers
  logic              res_read;
  logic              res_ok;
  logic              res_bottom;
  logic [FILL_W-1:0] res_bot_fill;
  logic [7:0]        res_bot_attr;
  logic [COL_W-1:0]  res_rcol;
  logic [COL_W-1:0]  res_cursor;
  logic              res_scroll;

  // exec-cycle logic
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  phys_row;
  logic              in_range;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              is_put;
  logic              is_newline;
  logic              last_col;
  logic              do_write;
  logic              do_scroll;
  logic [COL_W-1:0]  column_next;
  logic [ROW_W-1:0]  bottom_next;
  logic [FILL_W-1:0] old_fill;

  always_comb begin
    row_sum  = (ROW_W+1)'(bottom) + (ROW_W+1)'(1) + (ROW_W+1)'(in_row);
    if (row_sum >= (ROW_W+1)'(ROWS)) begin
      row_sum = row_sum - (ROW_W+1)'(ROWS);
    end
    phys_row = row_sum[ROW_W-1:0];
    in_range = (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLUMNS));
    rd_addr  = ADDR_W'(32'(phys_row) * COLUMNS + 32'(in_col));
    wr_addr  = ADDR_W'(32'(bottom) * COLUMNS + 32'(column));

    is_put     = (in_action == ACT_PUT);
    is_newline = is_put && (in_char == NEWLINE_CODE);
    last_col   = (32'(column) == 32'(COLUMNS - 1));
    do_write   = is_put && !is_newline;
    do_scroll  = is_newline || (do_write && last_col);
    old_fill   = is_newline ? FILL_W'(column) : FILL_W'(COLUMNS);

    column_next = column;
    if (do_scroll) begin
      column_next = '0;
    end else if (do_write) begin
      column_next = column + COL_W'(1);
    end

    bottom_next = bottom;
    if (do_scroll) begin
      if (32'(bottom) == 32'(ROWS - 1)) begin
        bottom_next = '0;
      end else begin
        bottom_next = bottom + ROW_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attr        <= RESET_ATTR;
      column      <= '0;
      bottom      <= ROW_W'(ROWS - 1);
      bottom_attr <= RESET_ATTR;
      meta_valid  <= '0;
    end else begin
      if (cfg_write) begin
        attr <= cfg_data;
      end
      if (cmd.exec) begin
        column <= column_next;
        bottom <= bottom_next;
        if (do_scroll) begin
          bottom_attr        <= attr;
          meta_valid[bottom] <= 1'b1;
        end
      end
    end
  end

  // payload registers and storage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_action <= action;
      in_char   <= char_code;
      in_row    <= read_row;
      in_col    <= read_column;
    end
    if (cmd.exec) begin
      if (do_write) begin
        screen[wr_addr] <= {attr, in_char};
      end
      if (do_scroll) begin
        // the row leaving the bottom keeps its written length and fill colour
        meta_fill[bottom] <= old_fill;
        meta_attr[bottom] <= bottom_attr;
      end
      mem_q        <= screen[rd_addr];
      meta_fill_q  <= meta_fill[phys_row];
      meta_attr_q  <= meta_attr[phys_row];
      meta_valid_q <= meta_valid[phys_row];
      res_read     <= (in_action == ACT_READ);
      res_ok       <= in_range;
      res_bottom   <= (phys_row == bottom);
      res_bot_fill <= FILL_W'(column);
      res_bot_attr <= bottom_attr;
      res_rcol     <= COL_W'(in_col);
      res_cursor   <= column_next;
      res_scroll   <= do_scroll;
    end
  end

  // result selection
  logic [FILL_W-1:0] fill_sel;
  logic [7:0]        attr_sel;

  always_comb begin
    if (res_bottom) begin
      fill_sel = res_bot_fill;
      attr_sel = res_bot_attr;
    end else if (meta_valid_q) begin
      fill_sel = meta_fill_q;
      attr_sel = meta_attr_q;
    end else begin
      fill_sel = '0;
      attr_sel = RESET_ATTR;
    end

    if (!res_read || !res_ok) begin
      cell_value = '0;
    end else if (FILL_W'(res_rcol) < fill_sel) begin
      cell_value = mem_q;
    end else begin
      cell_value = {attr_sel, SPACE_CODE};
    end

    cursor_column = 7'(res_cursor);
    cursor_row    = 5'(ROWS - 1);
    scrolled      = res_scroll;
  end

endmodule

[sim/tb_text_terminal_scroll_writer.sv]
// self-checking testbench for the text terminal scroll writer
// depends on tts_pkg and the text_terminal_scroll_writer rtl; drives commands, predicts every
// result from its own copy of the screen and compares each result beat as it appears
module tb_text_terminal_scroll_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;

  localparam int SCREEN_COLS = COLUMNS_DEF;
  localparam int SCREEN_ROWS = ROWS_DEF;
  localparam int CELL_TOTAL  = SCREEN_COLS * SCREEN_ROWS;
  localparam int IDLE_PCT    = 21;
  localparam int STALL_LIMIT = 2000;   // cycles with no beat of any kind
  localparam int REPORT_MAX  = 10;
  localparam int PHASE_ITEMS = 117;    // minimum random items per attribute setting

  // one command beat as presented on the input ports
  typedef struct packed {
    action_t    act;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } term_cmd_t;

  // one result beat
  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [15:0] cell_value;
    logic        scrolled;
  } term_result_t;

  logic        clk;
  logic        rst         = 1'b1;
  logic        start       = 1'b0;
  logic        busy;
  logic        action      = ACT_PUT;
  logic [7:0]  char_code   = '0;
  logic [4:0]  read_row    = '0;
  logic [6:0]  read_column = '0;
  logic        result_valid;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_row;
  logic [15:0] cell_value;
  logic        scrolled;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data    = '0;

  // predicted terminal state
  logic [15:0] screen_model [CELL_TOTAL];
  int          cursor_model;
  logic [7:0]  attr_model;

  term_cmd_t    pending_cmds[$];      // commands still to be driven
  term_result_t expected_results[$];  // predictions awaiting their result beat
  term_cmd_t    cmd_on_port;
  int           beats_taken   = 0;
  int           mismatch_count = 0;
  int           stall_cycles   = 0;

  text_terminal_scroll_writer DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .char_code    (char_code),
    .read_row     (read_row),
    .read_column  (read_column),
    .result_valid (result_valid),
    .cursor_column(cursor_column),
    .cursor_row   (cursor_row),
    .cell_value   (cell_value),
    .scrolled     (scrolled),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------

  // move every row up by one and blank the bottom row in the current colour
  function automatic void scroll_screen();
    for (int i = 0; i < CELL_TOTAL - SCREEN_COLS; i++)
      screen_model[i] = screen_model[i + SCREEN_COLS];
    for (int x = 0; x < SCREEN_COLS; x++)
      screen_model[CELL_TOTAL - SCREEN_COLS + x] = {attr_model, SPACE_CODE};
  endfunction

  // apply one accepted command to the model and return its result beat
  function automatic term_result_t advance_terminal(term_cmd_t c);
    term_result_t r;
    r = '0;
    if (c.act == ACT_READ) begin
      // reads off the edge of the screen give zero and touch nothing
      if (int'(c.row) < SCREEN_ROWS && int'(c.col) < SCREEN_COLS)
        r.cell_value = screen_model[int'(c.row) * SCREEN_COLS + int'(c.col)];
    end else if (c.ch == NEWLINE_CODE) begin
      // newline writes nothing, just returns the carriage and scrolls
      cursor_model = 0;
      scroll_screen();
      r.scrolled = 1'b1;
    end else begin
      screen_model[CELL_TOTAL - SCREEN_COLS + cursor_model] = {attr_model, c.ch};
      cursor_model++;
      // filling the last column wraps and scrolls in the same beat
      if (cursor_model == SCREEN_COLS) begin
        cursor_model = 0;
        scroll_screen();
        r.scrolled = 1'b1;
      end
    end
    r.cursor_column = cursor_model[6:0];
    r.cursor_row    = 5'(SCREEN_ROWS - 1);
    return r;
  endfunction

  // ---------------------------------------------------------------
  // command driver
  // ---------------------------------------------------------------

  // a beat goes in at an edge with start high and busy low; the slot is
  // refilled at that same edge, so start never drops between back-to-back
  // beats; a long stretch in the middle of the run has no random gaps
  always @(posedge clk) begin : command_driver
    logic gaps_on;
    gaps_on = !(beats_taken >= 250 && beats_taken < 400);
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(advance_terminal(cmd_on_port));
        beats_taken++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 &&
            !(gaps_on && $urandom_range(0, 99) < IDLE_PCT)) begin
          cmd_on_port = pending_cmds.pop_front();
          start       <= 1'b1;
          action      <= cmd_on_port.act;
          char_code   <= cmd_on_port.ch;
          read_row    <= cmd_on_port.row;
          read_column <= cmd_on_port.col;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------

  task automatic log_mismatch(input string what, input term_result_t want,
                              input term_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t %s: expected col %0d row %0d cell %h scr %0b, got col %0d row %0d cell %h scr %0b",
               $realtime, what, want.cursor_column, want.cursor_row, want.cell_value,
               want.scrolled, got.cursor_column, got.cursor_row, got.cell_value, got.scrolled);
  endtask

  // results cannot be held off, so every strobe is a beat to check
  always @(posedge clk) begin : result_monitor
    term_result_t got;
    term_result_t want;
    got = {cursor_column, cursor_row, cell_value, scrolled};
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        log_mismatch("result beat with nothing expected", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.cursor_column !== want.cursor_column || got.cursor_row !== want.cursor_row ||
            got.cell_value !== want.cell_value || got.scrolled !== want.scrolled)
          log_mismatch("result mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------
  // watchdog: any beat on any channel counts as progress
  // ---------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("tb_text_terminal_scroll_writer: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------

  task automatic queue_read(input int row, input int col);
    pending_cmds.push_back('{act: ACT_READ, ch: 8'($urandom), row: 5'(row), col: 7'(col)});
  endtask

  task automatic queue_put(input logic [7:0] ch);
    pending_cmds.push_back('{act: ACT_PUT, ch: ch, row: 5'($urandom), col: 7'($urandom)});
  endtask

  // any printable-or-not character except the newline code
  function automatic logic [7:0] random_glyph();
    logic [7:0] g;
    do g = 8'($urandom_range(0, 255)); while (g == NEWLINE_CODE);
    return g;
  endfunction

  // mostly cells near the bottom, where the text lands, sometimes off screen
  task automatic queue_random_read();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      queue_read($urandom_range(0, 31), $urandom_range(0, 127));
    else if (pick < 55)
      queue_read($urandom_range(SCREEN_ROWS - 5, SCREEN_ROWS - 1),
                 $urandom_range(0, SCREEN_COLS - 1));
    else
      queue_read($urandom_range(0, SCREEN_ROWS - 1), $urandom_range(0, SCREEN_COLS - 1));
  endtask

  // wait for the block to drain: nothing to drive, nothing in flight
  task automatic settle();
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // attribute write; only issued once settled
  task automatic write_attribute(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    attr_model = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] attr_list [6];
    int         phase_start;
    int         line_len;
    int         pick;

    // screen comes out of reset as grey-on-black spaces
    for (int i = 0; i < CELL_TOTAL; i++)
      screen_model[i] = {RESET_ATTR, SPACE_CODE};
    cursor_model = 0;
    attr_model   = RESET_ATTR;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset contents, corners, off-screen reads, extreme characters,
    // newline, newline at column zero, old rows after a scroll
    queue_read(0, 0);
    queue_read(SCREEN_ROWS - 1, SCREEN_COLS - 1);
    queue_read(12, 40);
    queue_read(SCREEN_ROWS, 0);
    queue_read(31, 127);
    queue_read(0, SCREEN_COLS);
    queue_read(SCREEN_ROWS - 1, 127);
    queue_put(8'h00);
    queue_put(8'hFF);
    queue_put(8'h41);
    queue_read(SCREEN_ROWS - 1, 0);
    queue_read(SCREEN_ROWS - 1, 1);
    queue_read(SCREEN_ROWS - 1, 2);
    queue_read(SCREEN_ROWS - 1, 3);
    queue_put(NEWLINE_CODE);
    queue_read(SCREEN_ROWS - 2, 0);
    queue_read(SCREEN_ROWS - 2, 2);
    queue_read(SCREEN_ROWS - 1, 0);
    queue_put(NEWLINE_CODE);
    queue_read(SCREEN_ROWS - 3, 1);
    queue_read(SCREEN_ROWS - 1, SCREEN_COLS - 1);
    settle();

    // random phases, each under its own attribute; both extremes first
    attr_list[0] = 8'hFF;
    attr_list[1] = 8'h00;
    for (int p = 2; p < 6; p++)
      attr_list[p] = 8'($urandom_range(0, 255));

    for (int p = 0; p < 6; p++) begin
      write_attribute(attr_list[p]);
      phase_start = pending_cmds.size();
      while (pending_cmds.size() - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // a line of text: short most of the time, now and then long enough to wrap
          line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(SCREEN_COLS - 5, SCREEN_COLS + 5)
                                                 : $urandom_range(0, 30);
          for (int k = 0; k < line_len; k++) begin
            queue_put(random_glyph());
            if ($urandom_range(0, 99) < 15)
              queue_random_read();
          end
          if ($urandom_range(0, 99) < 80)
            queue_put(NEWLINE_CODE);
        end else if (pick < 90) begin
          queue_random_read();
        end else begin
          // noise: any character, newline included
          queue_put(8'($urandom_range(0, 255)));
        end
      end
      settle();
    end

    // let any stray beat show up before the verdict
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("tb_text_terminal_scroll_writer: PASS");
    else
      $display("tb_text_terminal_scroll_writer: FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/tts_pkg.sv
rtl/tts_ctrl.sv
rtl/tts_dp.sv
rtl/text_terminal_scroll_writer.sv
sim/tb_text_terminal_scroll_writer.sv
